[src/gfq_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the feature grid index
// used by every file of the block but gfq_ram; no dependencies
package gfq_pkg;

  localparam int DEF_GRID_COLS    = 64;
  localparam int DEF_GRID_ROWS    = 48;
  localparam int DEF_MAX_FEATURES = 2048;
  localparam int DEF_MAX_HITS     = 64;

  localparam int POS_W   = 18;
  localparam int SCALE_W = 16;
  localparam int RAD_W   = 14;
  localparam int LVL_W   = 3;
  localparam int IDX_W   = 11;
  localparam int CFG_IW  = 3;
  localparam int MUL_AW  = 20;
  localparam int PROD_W  = MUL_AW + SCALE_W + 1;
  localparam int FRAC_W  = 20;
  localparam int CRD_W   = PROD_W + 1 - FRAC_W;

  localparam logic [SCALE_W-1:0] RST_SCALE = 16'd6554;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SCALE_X  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SCALE_Y  = 3'd3;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_INS_X, ST_INS_Y, ST_INS_C, ST_INS_W,
    ST_Q_C0, ST_Q_C1, ST_Q_R0, ST_Q_R1, ST_Q_RANGE, ST_Q_CELL, ST_Q_FEAT, ST_PUSH
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] feature_index;
    logic             hit_valid;
    logic             in_grid;
    logic             table_full;
    logic             hits_dropped;
    logic             last;
  } res_t;

  // floor of a Q.20 product
  function automatic logic signed [CRD_W-1:0] fx_floor(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p >>> FRAC_W;
    return CRD_W'(t);
  endfunction

  // ceil of a Q.20 product
  function automatic logic signed [CRD_W-1:0] fx_ceil(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W+1)'((1 << FRAC_W) - 1);
    return t[PROD_W:FRAC_W];
  endfunction

  // round to nearest, halves away from zero
  function automatic logic signed [CRD_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] w;
    logic [PROD_W:0] t;
    logic [CRD_W-1:0] u;
    w = {p[PROD_W-1], p};
    if (!p[PROD_W-1]) begin
      t = w + (PROD_W+1)'(1 << (FRAC_W - 1));
      return t[PROD_W:FRAC_W];
    end
    t = (-w) + (PROD_W+1)'(1 << (FRAC_W - 1));
    u = t[PROD_W:FRAC_W];
    return -u;
  endfunction

endpackage

[src/gfq_if.sv]
`timescale 1ns / 1ps
// channel interfaces: command input, result output and register writes
// depends on gfq_pkg for field widths
interface gfq_in_if;
  import gfq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [LVL_W-1:0]        key_octave;
  logic [RAD_W-1:0]        radius;
  logic signed [3:0]       min_level;
  logic signed [3:0]       max_level;
  modport source (output valid, opcode, pos_x, pos_y, key_octave, radius, min_level,
                  max_level, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, key_octave, radius, min_level,
                max_level, output ready);
endinterface

interface gfq_out_if;
  import gfq_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] feature_index;
  logic             hit_valid;
  logic             in_grid;
  logic             table_full;
  logic             hits_dropped;
  logic             last;
  modport source (output valid, feature_index, hit_valid, in_grid, table_full,
                  hits_dropped, last, input ready);
  modport sink (input valid, feature_index, hit_valid, in_grid, table_full,
                hits_dropped, last, output ready);
endinterface

interface gfq_cfg_if;
  import gfq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [POS_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/feature_grid_index_area_query_core.sv]
`timescale 1ns / 1ps
// grid index of keypoints: cell heads/tails and feature lists in block memories
// an insert stores, maps and links a feature (a full store or unused opcode only answers),
// a query computes its box, then walks each cell and each listed feature, a clear sweeps
// the cell memory; result stalls hold the work; one word is in work at a time
// throughput is set by the single read port of the cell and feature memories
// reset (synchronous, rst_n low) empties the store, then a clearing pass over
// every cell of the cell memory runs before the first word is taken
module feature_grid_index_area_query_core import gfq_pkg::*; #(
  parameter int GRID_COLS    = DEF_GRID_COLS,
  parameter int GRID_ROWS    = DEF_GRID_ROWS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int MAX_HITS     = DEF_MAX_HITS
) (
  input  logic      clk,
  input  logic      rst_n,
  gfq_in_if.sink    in_ch,
  gfq_out_if.source out_ch,
  gfq_cfg_if.sink   cfg_ch
);
  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int XW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int YW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int IW     = $clog2(MAX_FEATURES);
  localparam int CNTW   = IW + 1;
  localparam int HW     = $clog2(MAX_HITS + 1);
  localparam int CDW    = 1 + 2 * IW;
  localparam int FDW    = 2 * POS_W + LVL_W;

  localparam logic signed [CRD_W-1:0] COLS_S = CRD_W'(GRID_COLS);
  localparam logic signed [CRD_W-1:0] ROWS_S = CRD_W'(GRID_ROWS);

  // registers
  state_t                   state_r, state_nxt;
  logic signed [POS_W-1:0]  ox_r, oy_r;
  logic [SCALE_W-1:0]       sx_r, sy_r;
  logic [CNTW-1:0]          count_r, count_nxt;
  logic [AW-1:0]            sweep_r, sweep_nxt;
  logic                     clr_r, clr_nxt;
  logic signed [POS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [LVL_W-1:0]         lvl_r, lvl_nxt;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic signed [3:0]        minl_r, minl_nxt, maxl_r, maxl_nxt;
  logic signed [CRD_W-1:0]  cx_r, cx_nxt, c0_r, c0_nxt, c1_r, c1_nxt, r0_r, r0_nxt;
  logic [XW-1:0]            ix_r, ix_nxt, xhi_r, xhi_nxt;
  logic [YW-1:0]            iy_r, iy_nxt, ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [AW-1:0]            caddr_r, caddr_nxt;
  logic [IW-1:0]            j_r, j_nxt, tail_r, tail_nxt, pend_r, pend_nxt;
  logic                     pend_v_r, pend_v_nxt, drop_r, drop_nxt;
  logic [HW-1:0]            n_r, n_nxt;
  res_t                     res_r, res_nxt;
  logic                     out_v_r;
  res_t                     out_d_r;

  // memory ports
  logic            cram_we, cram_re;
  logic [AW-1:0]   cram_waddr, cram_raddr;
  logic [CDW-1:0]  cram_wdata, cram_rdata;
  logic            fram_we, fram_re, link_we;
  logic [IW-1:0]   fram_raddr, link_waddr, link_wdata;
  logic [FDW-1:0]  fram_rdata;
  logic [IW-1:0]   link_rdata;

  // multiplier
  logic signed [MUL_AW-1:0] mul_a;
  logic [SCALE_W-1:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // output staging
  logic push_v, can_push, do_adv;
  res_t push_d;

  // datapath helpers
  logic signed [POS_W:0]     dx, dy;
  logic signed [MUL_AW-1:0]  dxe, dye, rade;
  logic signed [CRD_W-1:0]   cy, r1s, c0c, c1c, r0c, r1c;
  logic                      ing, empty;
  logic                      c_used;
  logic [IW-1:0]             c_head, c_tail;
  logic signed [POS_W-1:0]   fx, fy;
  logic [LVL_W-1:0]          flv;
  logic signed [POS_W:0]     ddx, ddy;
  logic [POS_W:0]            adx, ady;
  logic                      chk, lvl_ok, hit;

  function automatic logic [AW-1:0] cell_at(input logic [XW-1:0] cx, input logic [YW-1:0] cy);
    return AW'(AW'(cx) * AW'(GRID_ROWS)) + AW'(cy);
  endfunction

  gfq_ram #(.DW(CDW), .DEPTH(NCELLS)) u_cell_ram (
    .clk(clk), .we(cram_we), .waddr(cram_waddr), .wdata(cram_wdata),
    .re(cram_re), .raddr(cram_raddr), .rdata_r(cram_rdata)
  );

  gfq_ram #(.DW(FDW), .DEPTH(MAX_FEATURES)) u_feat_ram (
    .clk(clk), .we(fram_we), .waddr(count_r[IW-1:0]), .wdata({x_r, y_r, lvl_r}),
    .re(fram_re), .raddr(fram_raddr), .rdata_r(fram_rdata)
  );

  gfq_ram #(.DW(IW), .DEPTH(MAX_FEATURES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(fram_re), .raddr(fram_raddr), .rdata_r(link_rdata)
  );

  gfq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  // fixed datapath terms
  assign dx   = $signed({x_r[POS_W-1], x_r}) - $signed({ox_r[POS_W-1], ox_r});
  assign dy   = $signed({y_r[POS_W-1], y_r}) - $signed({oy_r[POS_W-1], oy_r});
  assign dxe  = MUL_AW'(dx);
  assign dye  = MUL_AW'(dy);
  assign rade = $signed(MUL_AW'(rad_r));
  assign cy   = fx_round(mul_p);
  assign r1s  = fx_ceil(mul_p);
  assign ing  = !cx_r[CRD_W-1] && (cx_r < COLS_S) && !cy[CRD_W-1] && (cy < ROWS_S);

  // query range clamp
  assign c0c   = c0_r[CRD_W-1] ? '0 : c0_r;
  assign c1c   = (c1_r > COLS_S - 1) ? COLS_S - 1 : c1_r;
  assign r0c   = r0_r[CRD_W-1] ? '0 : r0_r;
  assign r1c   = (r1s > ROWS_S - 1) ? ROWS_S - 1 : r1s;
  assign empty = (c0_r >= COLS_S) || c1_r[CRD_W-1] || (r0_r >= ROWS_S) || r1s[CRD_W-1]
                 || (c0c > c1c) || (r0c > r1c);

  // cell word and feature word fields
  assign c_used = cram_rdata[CDW-1];
  assign c_head = cram_rdata[2*IW-1:IW];
  assign c_tail = cram_rdata[IW-1:0];
  assign {fx, fy, flv} = fram_rdata;

  // hit test of the listed feature
  assign ddx    = $signed({fx[POS_W-1], fx}) - $signed({x_r[POS_W-1], x_r});
  assign ddy    = $signed({fy[POS_W-1], fy}) - $signed({y_r[POS_W-1], y_r});
  assign adx    = ddx[POS_W] ? (POS_W+1)'(-ddx) : ddx;
  assign ady    = ddy[POS_W] ? (POS_W+1)'(-ddy) : ddy;
  assign chk    = (minl_r > 0) || !maxl_r[3];
  assign lvl_ok = !chk || (($signed({2'b00, flv}) >= $signed({minl_r[3], minl_r}))
                  && (maxl_r[3] || ($signed({2'b00, flv}) <= $signed({maxl_r[3], maxl_r}))));
  assign hit    = lvl_ok && (adx < (POS_W+1)'(rad_r)) && (ady < (POS_W+1)'(rad_r));

  assign can_push     = !out_v_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // next state and memory control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sweep_nxt  = sweep_r;
    clr_nxt    = clr_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    lvl_nxt    = lvl_r;
    rad_nxt    = rad_r;
    minl_nxt   = minl_r;
    maxl_nxt   = maxl_r;
    cx_nxt     = cx_r;
    c0_nxt     = c0_r;
    c1_nxt     = c1_r;
    r0_nxt     = r0_r;
    ix_nxt     = ix_r;
    iy_nxt     = iy_r;
    xhi_nxt    = xhi_r;
    ylo_nxt    = ylo_r;
    yhi_nxt    = yhi_r;
    caddr_nxt  = caddr_r;
    j_nxt      = j_r;
    tail_nxt   = tail_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    drop_nxt   = drop_r;
    n_nxt      = n_r;
    res_nxt    = res_r;
    mul_a      = dxe;
    mul_b      = sx_r;
    cram_we    = 1'b0;
    cram_waddr = caddr_r;
    cram_wdata = '0;
    cram_re    = 1'b0;
    cram_raddr = caddr_r;
    fram_we    = 1'b0;
    fram_re    = 1'b0;
    fram_raddr = j_r;
    link_we    = 1'b0;
    link_waddr = c_tail;
    link_wdata = count_r[IW-1:0];
    push_v     = 1'b0;
    push_d     = res_r;
    do_adv     = 1'b0;

    case (state_r)
      // clearing pass over the cell memory
      ST_SWEEP: begin
        cram_we    = 1'b1;
        cram_waddr = sweep_r;
        if (sweep_r == AW'(NCELLS - 1)) begin
          state_nxt = clr_r ? ST_PUSH : ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt    = in_ch.pos_x;
          y_nxt    = in_ch.pos_y;
          lvl_nxt  = in_ch.key_octave;
          rad_nxt  = in_ch.radius;
          minl_nxt = in_ch.min_level;
          maxl_nxt = in_ch.max_level;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          case (in_ch.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              sweep_nxt = '0;
              clr_nxt   = 1'b1;
              state_nxt = ST_SWEEP;
            end
            OP_INSERT: begin
              if (count_r == CNTW'(MAX_FEATURES)) begin
                res_nxt.table_full = 1'b1;
                state_nxt = ST_PUSH;
              end else begin
                state_nxt = ST_INS_X;
              end
            end
            OP_QUERY: state_nxt = ST_Q_C0;
            default:  state_nxt = ST_PUSH;
          endcase
        end
      end
      // insert: store feature, map to cell, link into list
      ST_INS_X: begin
        fram_we   = 1'b1;
        mul_a     = dxe;
        state_nxt = ST_INS_Y;
      end
      ST_INS_Y: begin
        cx_nxt    = fx_round(mul_p);
        mul_a     = dye;
        mul_b     = sy_r;
        state_nxt = ST_INS_C;
      end
      ST_INS_C: begin
        res_nxt.feature_index = IDX_W'(count_r[IW-1:0]);
        if (ing) begin
          caddr_nxt  = cell_at(XW'(cx_r), YW'(cy));
          cram_re    = 1'b1;
          cram_raddr = caddr_nxt;
          state_nxt  = ST_INS_W;
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_INS_W: begin
        cram_we = 1'b1;
        if (c_used) begin
          link_we    = 1'b1;
          cram_wdata = {1'b1, c_head, count_r[IW-1:0]};
        end else begin
          cram_wdata = {1'b1, count_r[IW-1:0], count_r[IW-1:0]};
        end
        count_nxt       = count_r + 1'b1;
        res_nxt.in_grid = 1'b1;
        state_nxt       = ST_PUSH;
      end
      // query: four box edges through the multiplier
      ST_Q_C0: begin
        mul_a     = dxe - rade;
        state_nxt = ST_Q_C1;
      end
      ST_Q_C1: begin
        c0_nxt    = fx_floor(mul_p);
        mul_a     = dxe + rade;
        state_nxt = ST_Q_R0;
      end
      ST_Q_R0: begin
        c1_nxt    = fx_ceil(mul_p);
        mul_a     = dye - rade;
        mul_b     = sy_r;
        state_nxt = ST_Q_R1;
      end
      ST_Q_R1: begin
        r0_nxt    = fx_floor(mul_p);
        mul_a     = dye + rade;
        mul_b     = sy_r;
        state_nxt = ST_Q_RANGE;
      end
      ST_Q_RANGE: begin
        n_nxt      = '0;
        drop_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
        if (empty) begin
          state_nxt = ST_PUSH;
        end else begin
          ix_nxt     = XW'(c0c);
          iy_nxt     = YW'(r0c);
          xhi_nxt    = XW'(c1c);
          ylo_nxt    = YW'(r0c);
          yhi_nxt    = YW'(r1c);
          cram_re    = 1'b1;
          cram_raddr = cell_at(XW'(c0c), YW'(r0c));
          state_nxt  = ST_Q_CELL;
        end
      end
      ST_Q_CELL: begin
        if (c_used) begin
          j_nxt      = c_head;
          tail_nxt   = c_tail;
          fram_re    = 1'b1;
          fram_raddr = c_head;
          state_nxt  = ST_Q_FEAT;
        end else begin
          do_adv = 1'b1;
        end
      end
      // list walk, one feature a cycle unless stalled; one hit held for last flag
      ST_Q_FEAT: begin
        if (!(hit && (n_r < HW'(MAX_HITS)) && pend_v_r && !can_push)) begin
          if (hit) begin
            if (n_r < HW'(MAX_HITS)) begin
              push_v = pend_v_r;
              push_d = '{feature_index: IDX_W'(pend_r), hit_valid: 1'b1, in_grid: 1'b0,
                         table_full: 1'b0, hits_dropped: 1'b0, last: 1'b0};
              pend_nxt   = j_r;
              pend_v_nxt = 1'b1;
              n_nxt      = n_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (j_r == tail_r) begin
            do_adv = 1'b1;
          end else begin
            j_nxt      = link_rdata;
            fram_re    = 1'b1;
            fram_raddr = link_rdata;
          end
        end
      end
      ST_PUSH: begin
        push_v = 1'b1;
        if (can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // step to the next cell, rows within a column
    if (do_adv) begin
      if (iy_r != yhi_r) begin
        iy_nxt     = iy_r + 1'b1;
        cram_re    = 1'b1;
        cram_raddr = cell_at(ix_r, iy_nxt);
        state_nxt  = ST_Q_CELL;
      end else if (ix_r != xhi_r) begin
        ix_nxt     = ix_r + 1'b1;
        iy_nxt     = ylo_r;
        cram_re    = 1'b1;
        cram_raddr = cell_at(ix_nxt, ylo_r);
        state_nxt  = ST_Q_CELL;
      end else begin
        res_nxt = '{feature_index: pend_v_nxt ? IDX_W'(pend_nxt) : '0, hit_valid: pend_v_nxt,
                    in_grid: 1'b0, table_full: 1'b0, hits_dropped: drop_nxt, last: 1'b1};
        state_nxt = ST_PUSH;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SWEEP;
      count_r  <= '0;
      sweep_r  <= '0;
      clr_r    <= 1'b0;
      pend_v_r <= 1'b0;
      drop_r   <= 1'b0;
      n_r      <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sweep_r  <= sweep_nxt;
      clr_r    <= clr_nxt;
      pend_v_r <= pend_v_nxt;
      drop_r   <= drop_nxt;
      n_r      <= n_nxt;
      if (push_v && can_push) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    lvl_r   <= lvl_nxt;
    rad_r   <= rad_nxt;
    minl_r  <= minl_nxt;
    maxl_r  <= maxl_nxt;
    cx_r    <= cx_nxt;
    c0_r    <= c0_nxt;
    c1_r    <= c1_nxt;
    r0_r    <= r0_nxt;
    ix_r    <= ix_nxt;
    iy_r    <= iy_nxt;
    xhi_r   <= xhi_nxt;
    ylo_r   <= ylo_nxt;
    yhi_r   <= yhi_nxt;
    caddr_r <= caddr_nxt;
    j_r     <= j_nxt;
    tail_r  <= tail_nxt;
    pend_r  <= pend_nxt;
    res_r   <= res_nxt;
    if (push_v && can_push) begin
      out_d_r <= push_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      sx_r <= RST_SCALE;
      sy_r <= RST_SCALE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ORIGIN_X: ox_r <= $signed(cfg_ch.data);
        REG_ORIGIN_Y: oy_r <= $signed(cfg_ch.data);
        REG_SCALE_X:  sx_r <= cfg_ch.data[SCALE_W-1:0];
        REG_SCALE_Y:  sy_r <= cfg_ch.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // result port
  assign out_ch.valid         = out_v_r;
  assign out_ch.feature_index = out_d_r.feature_index;
  assign out_ch.hit_valid     = out_d_r.hit_valid;
  assign out_ch.in_grid       = out_d_r.in_grid;
  assign out_ch.table_full    = out_d_r.table_full;
  assign out_ch.hits_dropped  = out_d_r.hits_dropped;
  assign out_ch.last          = out_d_r.last;
endmodule

[src/gfq_ram.sv]
`timescale 1ns / 1ps
// simple dual-port memory, one write and one registered read per cycle
// no dependencies
module gfq_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
  input  logic [DW-1:0]                         wdata,
  input  logic                                  re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
  output logic [DW-1:0]                         rdata_r
);
  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

[src/gfq_mul.sv]
`timescale 1ns / 1ps
// registered signed offset times unsigned Q0.20 scale, cell coordinates in Q.20
// depends on gfq_pkg
module gfq_mul import gfq_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_AW-1:0]  a,
  input  logic [SCALE_W-1:0]        b,
  output logic signed [PROD_W-1:0]  p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * $signed({1'b0, b});
  end
endmodule

[src/gfq_check.sv]
`timescale 1ns / 1ps
// port-level checks on the result channel of the grid index
// depends on gfq_pkg, bound to feature_grid_index_area_query_core
module gfq_check import gfq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_feature_index,
  input logic             out_hit_valid,
  input logic             out_in_grid,
  input logic             out_table_full,
  input logic             out_hits_dropped,
  input logic             out_last
);
  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // a stalled word keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_feature_index) && $stable(out_last))
    else $error("result payload changed while stalled");

  // query hits carry no insert flags
  a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_valid |-> !out_in_grid && !out_table_full)
    else $error("hit word carries insert flags");

  // overflow flag only on the closing word
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hits_dropped |-> out_last && out_hit_valid)
    else $error("dropped-hits flag off the closing word");

  // a rejected insert gives a single zero-index word
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_last && out_feature_index == '0
      && !out_in_grid)
    else $error("malformed store-full word");
endmodule

bind feature_grid_index_area_query_core gfq_check u_gfq_check (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_feature_index(out_ch.feature_index), .out_hit_valid(out_ch.hit_valid),
  .out_in_grid(out_ch.in_grid), .out_table_full(out_ch.table_full),
  .out_hits_dropped(out_ch.hits_dropped), .out_last(out_ch.last)
);
